// File: rtl/core/c3pc_pkg.sv
// Shared types and constants of the 3x3 pseudocolor convolution block.
// Used by the window cells, the output buffer and the top level; no dependencies.
package c3pc_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = 17;
    localparam int PART_W     = 18;
    localparam int SUM_W      = 20;
    localparam int SCALED_W   = 23;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int KROW_W     = 24;
    localparam int RGB_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [RGB_W-1:0]  COLOR_ZERO   = 24'hAAAAAA;

    // One window column: index 0 is the top row, 2 the bottom row.
    typedef logic [2:0][PIX_W-1:0] t_col;
    // Coefficients of one kernel column, same row order, two's complement.
    typedef logic [2:0][COEF_W-1:0] t_coefs;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_meta;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        t_meta            meta;
    } t_result;

endpackage

// File: rtl/core/conv3x3_signed_pseudocolor_top.sv
// 3x3 signed convolution with pseudocolor output over a raster grayscale stream.
// Throughput: one pixel word per cycle, set by the single line-store RAM port pair, while
// the output buffer is not full. Results go through the line store, window cells and scaling.
// Reset (synchronous, active low) holds both ready outputs low, restores the registers,
// zeroes the counters and the window cells; the line store is not cleared and needs no sweep.
// Depends on c3pc_pkg, c3pc_ram, c3pc_cell and c3pc_obuf.
module conv3x3_signed_pseudocolor_top import c3pc_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Pixel input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] gray_pixel
    input  logic                  s_axis_tuser,  // [0] frame_start
    // Pseudocolor result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // [23:0] color_rgb, [35:24] center_column,
                                                 // [47:36] center_row
    output logic                  m_axis_tlast   // frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    // Width compares need room for both the 13-bit register and MAX_WIDTH itself.
    localparam int SW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam int LW = 2 * PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers. The port pushes back only during reset.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] r_image_width;
    logic [SIZE_W-1:0] r_image_height;
    logic [KROW_W-1:0] r_kernel_top;
    logic [KROW_W-1:0] r_kernel_middle;
    logic [KROW_W-1:0] r_kernel_bottom;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= WIDTH_RESET;
            r_image_height  <= HEIGHT_RESET;
            r_kernel_top    <= '0;
            r_kernel_middle <= '0;
            r_kernel_bottom <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[SIZE_W-1:0];
                CFG_KERNEL_TOP:    r_kernel_top    <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: r_kernel_middle <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: r_kernel_bottom <= i_cfg_data[KROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sizes in use, clamped to what the counters and the line store support.
    logic [SW-1:0]     width_ext;
    logic [SW-1:0]     width_use;
    logic [SIZE_W-1:0] height_use;

    always_comb begin
        width_ext = SW'(r_image_width);
        if (width_ext < SW'(MIN_SIZE)) begin
            width_use = SW'(MIN_SIZE);
        end else if (width_ext > SW'(MAX_WIDTH)) begin
            width_use = SW'(MAX_WIDTH);
        end else begin
            width_use = width_ext;
        end
        if (r_image_height < SIZE_W'(MIN_SIZE)) begin
            height_use = SIZE_W'(MIN_SIZE);
        end else if (r_image_height > SIZE_W'(MAX_HEIGHT)) begin
            height_use = SIZE_W'(MAX_HEIGHT);
        end else begin
            height_use = r_image_height;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable. Every stage moves together; only a full output
    // buffer holds the pipeline, so one waiting result does not stop input.
    // No pixel word is taken while reset is asserted.
    // ------------------------------------------------------------------
    logic obuf_full;
    logic en;
    logic accept;

    assign en            = !obuf_full;
    assign s_axis_tready = en && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Stage 0: position counters. A frame_start word zeroes them before use.
    // ------------------------------------------------------------------
    logic [AW-1:0]      r_col_cnt;
    logic [COORD_W-1:0] r_row_cnt;
    logic [AW-1:0]      col_eff;
    logic [COORD_W-1:0] row_eff;
    logic [SW-1:0]      col_ext;
    logic [SW-1:0]      col_next;
    logic [SIZE_W-1:0]  row_ext;
    logic [SIZE_W-1:0]  row_next;
    logic               col_wrap;
    logic               row_wrap;
    logic               produce0;
    t_meta              meta0;

    always_comb begin
        col_eff  = s_axis_tuser ? '0 : r_col_cnt;
        row_eff  = s_axis_tuser ? '0 : r_row_cnt;
        col_ext  = SW'(col_eff);
        row_ext  = SIZE_W'(row_eff);
        col_next = col_ext + SW'(1);
        row_next = row_ext + SIZE_W'(1);
        col_wrap = (col_next >= width_use);
        row_wrap = (row_next >= height_use);
        // The window is complete once two rows and two columns have passed;
        // counters left beyond a shrunken size give no result.
        produce0 = (row_ext >= SIZE_W'(2)) && (col_ext >= SW'(2))
                && (row_ext < height_use) && (col_ext < width_use);
        meta0.col  = COORD_W'(col_ext - SW'(1));
        meta0.row  = row_eff - COORD_W'(1);
        meta0.last = (row_ext == height_use - SIZE_W'(1))
                  && (col_ext == width_use - SW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col_cnt <= '0;
                r_row_cnt <= row_wrap ? '0 : row_next[COORD_W-1:0];
            end else begin
                r_col_cnt <= col_next[AW-1:0];
                r_row_cnt <= row_eff;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one RAM word per column holds the two previous rows,
    // upper row in the high byte. Read in stage 0, written back in stage 1.
    // ------------------------------------------------------------------
    logic          r_v1;
    logic [7:0]    r_pix1;
    logic [AW-1:0] r_addr1;
    logic          r_keep1;
    t_meta         r_meta1;
    logic          r_fwd1;
    logic [LW-1:0] r_fwd_data1;
    logic [LW-1:0] ram_rdata;
    logic [LW-1:0] line1;
    logic [LW-1:0] wdata1;
    t_col          col_new;

    // A word that reads the column just being written (two frame_start words
    // in a row) takes the fresh data from the forwarding register.
    assign line1   = r_fwd1 ? r_fwd_data1 : ram_rdata;
    assign col_new = {r_pix1, line1[PIX_W-1:0], line1[LW-1:PIX_W]};
    assign wdata1  = {line1[PIX_W-1:0], r_pix1};

    c3pc_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (en && r_v1),
        .i_waddr (r_addr1),
        .i_wdata (wdata1),
        .i_re    (en),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_keep1 <= 1'b0;
        end else if (en) begin
            r_v1    <= accept;
            r_keep1 <= accept && produce0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix1      <= s_axis_tdata;
            r_addr1     <= col_eff;
            r_meta1     <= meta0;
            r_fwd1      <= r_v1 && (col_eff == r_addr1);
            r_fwd_data1 <= wdata1;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: chain of window cells. Cell 2 takes the new column,
    // each cell hands its column to the next older one, and every cell
    // registers its column's dot product with the matching kernel column.
    // ------------------------------------------------------------------
    logic                     r_keep2;
    t_meta                    r_meta2;
    logic                     r_keep3;
    t_meta                    r_meta3;
    t_col                     cell_in  [3];
    t_col                     cell_out [3];
    t_coefs                   cell_coef [3];
    logic signed [PART_W-1:0] cell_part [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cell_coef[k][0] = r_kernel_top[COEF_W*k +: COEF_W];
            cell_coef[k][1] = r_kernel_middle[COEF_W*k +: COEF_W];
            cell_coef[k][2] = r_kernel_bottom[COEF_W*k +: COEF_W];
        end
        cell_in[2] = col_new;
        cell_in[1] = cell_out[2];
        cell_in[0] = cell_out[1];
    end

    for (genvar g = 0; g < 3; g++) begin : g_cell
        c3pc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (en && r_v1),
            .i_en    (en),
            .i_col   (cell_in[g]),
            .i_coef  (cell_coef[g]),
            .o_col   (cell_out[g]),
            .o_part  (cell_part[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: total of the three partial sums, scaled by five as 4s + s.
    // ------------------------------------------------------------------
    logic                       r_keep4;
    t_meta                      r_meta4;
    logic signed [SCALED_W-1:0] r_scaled4;
    logic signed [SUM_W-1:0]    sum3;
    logic signed [SCALED_W-1:0] sum3_ext;

    assign sum3     = SUM_W'(cell_part[0]) + SUM_W'(cell_part[1]) + SUM_W'(cell_part[2]);
    assign sum3_ext = SCALED_W'(sum3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep2 <= 1'b0;
            r_keep3 <= 1'b0;
            r_keep4 <= 1'b0;
        end else if (en) begin
            r_keep2 <= r_keep1;
            r_keep3 <= r_keep2;
            r_keep4 <= r_keep3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta2   <= r_meta1;
            r_meta3   <= r_meta2;
            r_meta4   <= r_meta3;
            r_scaled4 <= (sum3_ext <<< 2) + sum3_ext;
        end
    end

    // ------------------------------------------------------------------
    // Pseudocolor map: positive values shade toward red, negative toward
    // blue, both saturated at 255; an exact zero gives a neutral gray.
    // ------------------------------------------------------------------
    function automatic logic [RGB_W-1:0] f_color(input logic signed [SCALED_W-1:0] s);
        logic signed [SCALED_W-1:0] neg;
        logic [7:0]                 v;
        logic [RGB_W-1:0]           rgb;
        neg = -s;
        v   = 8'hFF;
        if (s > SCALED_W'(0)) begin
            v   = (s > SCALED_W'(255)) ? 8'hFF : s[7:0];
            rgb = {v, ~v, ~v};
        end else if (s < SCALED_W'(0)) begin
            v   = (neg > SCALED_W'(255)) ? 8'hFF : neg[7:0];
            rgb = {~v, ~v, v};
        end else begin
            rgb = COLOR_ZERO;
        end
        return rgb;
    endfunction

    t_result result4;
    t_result obuf_data;

    always_comb begin
        result4.rgb  = f_color(r_scaled4);
        result4.meta = r_meta4;
    end

    c3pc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && r_keep4),
        .i_data  (result4),
        .o_full  (obuf_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (obuf_data)
    );

    assign m_axis_tdata = {obuf_data.meta.row, obuf_data.meta.col, obuf_data.rgb};
    assign m_axis_tlast = obuf_data.meta.last;

endmodule

// File: rtl/core/c3pc_ram.sv
// Generic simple dual-port RAM with registered read and read-old-data behavior.
// No dependencies.
module c3pc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/c3pc_cell.sv
// One window cell: holds a three-pixel column, passes it on when shifted,
// and registers the column's dot product with its kernel column. Uses c3pc_pkg.
module c3pc_cell import c3pc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  logic                     i_en,
    input  t_col                     i_col,
    input  t_coefs                   i_coef,
    output t_col                     o_col,
    output logic signed [PART_W-1:0] o_part
);

    t_col                     r_col;
    logic signed [PART_W-1:0] r_part;
    logic signed [PART_W-1:0] n_part;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        n_part = '0;
        prod   = '0;
        for (int i = 0; i < 3; i++) begin
            prod   = $signed({1'b0, r_col[i]}) * $signed(i_coef[i]);
            n_part = n_part + PART_W'(prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part <= n_part;
        end
    end

    assign o_col  = r_col;
    assign o_part = r_part;

endmodule

// File: rtl/core/c3pc_obuf.sv
// Two-entry output buffer that decouples the pipeline from the result consumer.
// Uses c3pc_pkg for the result type.
module c3pc_obuf import c3pc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
